/* rtl/f19m_pkg.sv */
package f19m_pkg;
  localparam int unsigned EXP_BITS_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF = 10;
endpackage

/* rtl/float19_multiplier.sv */
// Floating-point multiplier for a small float format (sign, EXP_BITS exponent with bias
// 2^(EXP_BITS-1)-1, FRAC_BITS fraction; 19 bits by default). Subnormal operands are
// normalized, the significand product is rounded to nearest even, overflow gives a signed
// infinity and tiny results a truncated subnormal or signed zero; NaN or infinity times
// zero gives the positive NaN with fraction 1. One operand pair is taken every cycle while
// in_stall_o is low; each pair passes through the operand register, then the result register,
// and a stalled result register holds while one more pair waits in the operand register.
module float19_multiplier #(
  parameter int unsigned EXP_BITS = f19m_pkg::EXP_BITS_DEF,
  parameter int unsigned FRAC_BITS = f19m_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [EXP_BITS+FRAC_BITS:0]    operand_a_i,
  input  logic [EXP_BITS+FRAC_BITS:0]    operand_b_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [EXP_BITS+FRAC_BITS:0]    product_o
);
  import f19m_pkg::*;

  localparam int unsigned W = 1 + EXP_BITS + FRAC_BITS;
  localparam int unsigned EW = EXP_BITS + 3;
  localparam int unsigned PW = 2 * FRAC_BITS + 2;
  localparam int unsigned LW = $clog2(FRAC_BITS + 1);
  localparam logic [EXP_BITS-1:0] EXP_ONES = '1;
  localparam logic signed [EW-1:0] BIAS = EW'((1 << (EXP_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] EMAX = EW'((1 << EXP_BITS) - 1);

  logic         a_valid_q, r_valid_q;
  logic [W-1:0] a_q, b_q, r_q;
  logic [W-1:0] r_d;
  logic         a_adv, r_adv;

  assign r_adv = !r_valid_q || !out_stall_i;
  assign a_adv = !a_valid_q || r_adv;
  assign in_stall_o = !a_adv;
  assign out_valid_o = r_valid_q;
  assign product_o = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      if (a_adv) a_valid_q <= in_valid_i;
      if (r_adv) r_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
    end
    if (r_adv && a_valid_q) r_q <= r_d;
  end

  function automatic logic [LW-1:0] lead_zeros(input logic [FRAC_BITS-1:0] f);
    logic [LW-1:0] n;
    logic          hit;
    n = '0;
    hit = 1'b0;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      if (!hit && !f[i]) n = n + LW'(1);
      else hit = 1'b1;
    end
    return n;
  endfunction

  logic [EXP_BITS-1:0]  ea, eb;
  logic [FRAC_BITS-1:0] fa, fb;
  logic                 sign, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [LW-1:0]        za, zb;
  logic [FRAC_BITS:0]   ma, mb, m, m_rnd;
  logic signed [EW-1:0] xa, xb, expo, shift;
  logic [PW-1:0]        p, pn;
  logic                 rb, sb;
  logic [FRAC_BITS+1:0] m_inc;

  always_comb begin
    sign = a_q[W-1] ^ b_q[W-1];
    ea = a_q[W-2:FRAC_BITS];
    eb = b_q[W-2:FRAC_BITS];
    fa = a_q[FRAC_BITS-1:0];
    fb = b_q[FRAC_BITS-1:0];
    nan_a = (ea == EXP_ONES) && (fa != '0);
    nan_b = (eb == EXP_ONES) && (fb != '0);
    inf_a = (ea == EXP_ONES) && (fa == '0);
    inf_b = (eb == EXP_ONES) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
    za = lead_zeros(fa);
    zb = lead_zeros(fb);
    if (ea != '0) begin
      ma = {1'b1, fa};
      xa = EW'(ea);
    end else begin
      ma = {1'b0, fa} << (za + LW'(1));
      xa = -EW'(za);
    end
    if (eb != '0) begin
      mb = {1'b1, fb};
      xb = EW'(eb);
    end else begin
      mb = {1'b0, fb} << (zb + LW'(1));
      xb = -EW'(zb);
    end
    expo = xa + xb - BIAS;
    p = PW'(ma) * PW'(mb);
    if (p[PW-1]) begin
      pn = (p >> 1) | PW'(p[0]);
      expo = expo + EW'(1);
    end else begin
      pn = p;
    end
    m = pn[2*FRAC_BITS:FRAC_BITS];
    rb = pn[FRAC_BITS-1];
    sb = (pn[FRAC_BITS-2:0] != '0);
    m_inc = {1'b0, m} + (FRAC_BITS+2)'(rb && (sb || m[0]));
    if (m_inc[FRAC_BITS+1]) begin
      m_rnd = m_inc[FRAC_BITS+1:1];
      expo = expo + EW'(1);
    end else begin
      m_rnd = m_inc[FRAC_BITS:0];
    end
    shift = EW'(1) - expo;

    if (nan_a || nan_b || ((inf_a || inf_b) && (zero_a || zero_b))) begin
      r_d = {1'b0, EXP_ONES, FRAC_BITS'(1)};
    end else if (inf_a || inf_b) begin
      r_d = {sign, EXP_ONES, FRAC_BITS'(0)};
    end else if (zero_a || zero_b) begin
      r_d = {sign, (W-1)'(0)};
    end else if (expo >= EMAX) begin
      r_d = {sign, EXP_ONES, FRAC_BITS'(0)};
    end else if (expo >= EW'(1)) begin
      r_d = {sign, expo[EXP_BITS-1:0], m_rnd[FRAC_BITS-1:0]};
    end else if (shift > EW'(FRAC_BITS)) begin
      r_d = {sign, (W-1)'(0)};
    end else begin
      r_d = {sign, EXP_BITS'(0), FRAC_BITS'(m_rnd >> shift)};
    end
  end
endmodule

/* dv/tb_float19_multiplier.sv */
module tb_float19_multiplier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EB = f19m_pkg::EXP_BITS_DEF;
  localparam int unsigned FB = f19m_pkg::FRAC_BITS_DEF;
  localparam int unsigned WB = 1 + EB + FB;
  localparam int EMAX = (1 << EB) - 1;
  localparam int BIAS = (1 << (EB - 1)) - 1;
  localparam logic [WB-1:0] QNAN = {1'b0, {EB{1'b1}}, {(FB-1){1'b0}}, 1'b1};

  typedef logic [WB-1:0] word_t;
  typedef struct packed {
    word_t a;
    word_t b;
  } operands_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  word_t operand_a_i = '0;
  word_t operand_b_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  word_t product_o;

  operands_t pending_q[$];
  word_t expected_products[$];
  int errors = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 58;
  int hold_cycles = 0;
  bit sender_paused = 1'b0;

  float19_multiplier u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .product_o(product_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned norm_sig(word_t x, output int e);
    longint unsigned fr;
    int ex;
    ex = int'(x[WB-2:FB]);
    fr = longint'(x[FB-1:0]);
    if (ex != 0) begin
      e = ex;
      return fr | (64'd1 << FB);
    end
    e = 1;
    for (int n = 0; n < FB && fr[FB] == 1'b0; n++) begin
      fr = fr << 1;
      e--;
    end
    return fr;
  endfunction

  function automatic word_t float_product(word_t a, word_t b);
    logic sgn;
    int ea, eb, xa, xb, expo, sh;
    longint unsigned fa, fb, ma, mb, p, m;
    logic r, s;
    word_t res;
    sgn = a[WB-1] ^ b[WB-1];
    ea = int'(a[WB-2:FB]);
    eb = int'(b[WB-2:FB]);
    fa = longint'(a[FB-1:0]);
    fb = longint'(b[FB-1:0]);
    if ((ea == EMAX && fa != 0) || (eb == EMAX && fb != 0)) return QNAN;
    if ((ea == EMAX) || (eb == EMAX)) begin
      if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return QNAN;
      return {sgn, {EB{1'b1}}, {FB{1'b0}}};
    end
    if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return {sgn, {(WB-1){1'b0}}};
    ma = norm_sig(a, xa);
    mb = norm_sig(b, xb);
    expo = xa + xb - BIAS;
    p = ma * mb;
    if ((p >> (2 * FB + 1)) != 0) begin
      p = (p >> 1) | (p & 1);
      expo++;
    end
    m = p >> FB;
    r = p[FB-1];
    s = (p & ((64'd1 << (FB - 1)) - 1)) != 0;
    if (r && (s || m[0])) m++;
    if ((m >> (FB + 1)) != 0) begin
      m = m >> 1;
      expo++;
    end
    if (expo >= EMAX) return {sgn, {EB{1'b1}}, {FB{1'b0}}};
    res = '0;
    res[WB-1] = sgn;
    if (expo >= 1) begin
      res[WB-2:FB] = expo[EB-1:0];
      res[FB-1:0] = m[FB-1:0];
      return res;
    end
    sh = 1 - expo;
    if (sh > FB) return res;
    res[FB-1:0] = FB'(m >> sh);
    return res;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_products.push_back(float_product(operand_a_i, operand_b_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && !sender_paused &&
            $urandom_range(99) >= send_idle_pct) begin
          operands_t it;
          it = pending_q.pop_front();
          operand_a_i <= it.a;
          operand_b_i <= it.b;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall and monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_products.size() == 0) begin
          report_mismatch("unexpected transfer", product_o, '0);
        end else begin
          word_t want;
          want = expected_products.pop_front();
          if (product_o !== want) report_mismatch("product", product_o, want);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic word_t rand_word();
    word_t w;
    w = word_t'($urandom);
    case ($urandom_range(7))
      0: w[WB-2:FB] = '0;
      1: w[WB-2:FB] = '1;
      2: w[WB-2:FB] = EB'($urandom_range(BIAS + 20, BIAS - 20));
      3: w[WB-2:FB] = EB'($urandom_range(BIAS / 2 + 8, BIAS / 2 - 8));
      4: w[WB-2:FB] = EB'($urandom_range(EMAX - 1, EMAX - 70));
      default: ;
    endcase
    if ($urandom_range(9) == 0) w[FB-1:0] = '0;
    return w;
  endfunction

  task automatic add_pair(word_t a, word_t b);
    operands_t it;
    it.a = a;
    it.b = b;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expected_products.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) add_pair(rand_word(), rand_word());
  endtask

  initial begin
    word_t one, inf, big, sub_max, sub_min, nan_x;
    one = word_t'(BIAS) << FB;
    inf = word_t'(EMAX) << FB;
    big = (word_t'(EMAX - 1) << FB) | word_t'((1 << FB) - 1);
    sub_max = word_t'((1 << FB) - 1);
    sub_min = word_t'(1);
    nan_x = inf | word_t'(1 << (FB - 1));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed corners
    add_pair(one, one);
    add_pair(nan_x, one);
    add_pair(one, inf | word_t'(1));
    add_pair(inf, '0);
    add_pair(word_t'(1) << (WB - 1), inf);
    add_pair(inf, sub_min | (word_t'(1) << (WB - 1)));
    add_pair(inf, big);
    add_pair('0, big | (word_t'(1) << (WB - 1)));
    add_pair(sub_max, '0);
    add_pair(big, big);
    add_pair(big, one);
    add_pair(sub_min, sub_min);
    add_pair(sub_max, one);
    add_pair(sub_max, (word_t'(BIAS + 1) << FB));
    add_pair(sub_min, (word_t'(BIAS + FB) << FB));
    add_pair(one | sub_max, one | sub_max);
    add_pair(one | word_t'(1), one | word_t'((1 << FB) - 1));
    add_pair(one | word_t'(1 << (FB - 1)), one | word_t'(1));
    add_pair((word_t'(1) << FB) | word_t'(1 << (FB - 1)), word_t'(BIAS - 2) << FB);
    add_pair('1, '1);
    add_pair(word_t'(1) << FB, word_t'(1) << FB);
    add_pair(big | (word_t'(1) << (WB - 1)), word_t'(BIAS - 5) << FB);
    drain();
    add_random(150);
    drain();
    send_idle_pct = 58;
    recv_idle_pct = 6;
    add_random(150);
    // long receiver hold while the sender keeps offering
    hold_cycles = 40;
    drain();
    // sender pause until everything has come back
    sender_paused = 1'b1;
    drain();
    sender_paused = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(130);
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("float19_multiplier test passed");
    end else begin
      $display("float19_multiplier test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("float19_multiplier test failed");
    $finish;
  end
endmodule
